// File: src/xcd_pkg.sv
// Package for the UTF-8 / UTF-32 transcoder: payload structs, queue entry type,
// constants and register map codes. No dependencies.
package xcd_pkg;

	localparam int DATA_W      = 32;
	localparam int CP_W        = 21;
	localparam int QUEUE_DEPTH = 4;
	localparam int ADDR_W      = 3;

	localparam logic [DATA_W-1:0] REPLACEMENT_CP = 32'h0000_FFFD;
	localparam logic [DATA_W-1:0] LIMIT_1B       = 32'h0000_0080;
	localparam logic [DATA_W-1:0] LIMIT_2B       = 32'h0000_0800;
	localparam logic [DATA_W-1:0] LIMIT_3B       = 32'h0001_0000;

	// Register index codes (byte address bits above the word offset).
	localparam logic REG_DIRECTION = 1'b0;

	// Direction codes.
	localparam logic DIR_DECODE = 1'b0;
	localparam logic DIR_ENCODE = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] in_data;
		logic              in_last;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] out_data;
		logic              out_last;
		logic              out_end;
	} out_item_t;

	// One queued job: a full code point (cnt 0) or up to four bytes, byte 0 in [7:0].
	typedef struct packed {
		logic [DATA_W-1:0] word;
		logic [1:0]        cnt;
		logic              fin;
	} job_t;

endpackage

// File: src/utf8_utf32_transcoder_core.sv
// Top level of the UTF-8 / UTF-32 transcoder: register port, front end, job queue
// and back end. Depends on xcd_pkg, xcd_front, xcd_queue and xcd_back.
//
//   channel  direction  payload      handshake
//   in       input      in_item_t    in_valid / in_stall
//   out      output     out_item_t   out_valid / out_stall
//   cfg      input      direction    psel / penable / pwrite / pready
//
// One input item is accepted per cycle while the job queue has room.
// A decode item's code point, if any, enters the job queue at the edge that accepts it.
// An encode item gives one result per UTF-8 byte (1 to 4) from the back end;
// the queue absorbs bursts and fills on long runs of multi-byte characters or output stalls.
// Reset clears the direction, the decode state, the queue and the output valid flag.
// in_stall is high exactly while the queue is full.
module utf8_utf32_transcoder_core import xcd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic dir_q;
	logic cfg_wr;
	logic accept;
	logic push;
	job_t push_job;
	logic pop;
	job_t head;
	logic empty;
	logic full;

	// Register port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
	assign prdata = (paddr[2] == REG_DIRECTION) ? {31'h0, dir_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_DECODE;
		end else if (cfg_wr) begin
			dir_q <= pwdata[0];
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	xcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_item   (in_item),
		.dir       (dir_q),
		.cfg_clear (cfg_wr),
		.push      (push),
		.push_job  (push_job)
	);

	xcd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push && accept),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	xcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule

// File: src/xcd_front.sv
// Front end of the transcoder: accepts input items, runs the UTF-8 decode state
// and builds one queue job per item that gives results. Depends on xcd_pkg.
module xcd_front import xcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t in_item,
	input  logic     dir,
	input  logic     cfg_clear,
	output logic     push,
	output job_t     push_job
);

	logic [CP_W-1:0] pend_q;
	logic [1:0]      left_q;
	logic [CP_W-1:0] pend_nxt;
	logic [1:0]      left_nxt;
	logic [7:0]      b;
	logic [DATA_W-1:0] cp;
	logic [CP_W-1:0] shifted;
	logic [1:0]      left_dec;

	assign b        = in_item.in_data[7:0];
	assign cp       = in_item.in_data;
	assign shifted  = {pend_q[CP_W-7:0], b[5:0]};
	assign left_dec = left_q - 2'd1;

	// Classify the item and form its job; decode state moves only on decode items.
	always_comb begin
		push          = 1'b0;
		push_job      = '0;
		push_job.fin  = in_item.in_last;
		pend_nxt      = pend_q;
		left_nxt      = left_q;
		if (dir == DIR_ENCODE) begin
			push = 1'b1;
			if (cp < LIMIT_1B) begin
				push_job.cnt  = 2'd0;
				push_job.word = cp;
			end else if (cp < LIMIT_2B) begin
				push_job.cnt  = 2'd1;
				push_job.word = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
			end else if (cp < LIMIT_3B) begin
				push_job.cnt  = 2'd2;
				push_job.word = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
			end else begin
				push_job.cnt  = 2'd3;
				push_job.word = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
					8'hF0 | cp[25:18]};
			end
		end else if (left_q == 2'd0) begin
			if (b[7] == 1'b0) begin
				push          = 1'b1;
				push_job.word = {24'h0, b};
			end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
				if (b[7:5] == 3'b110) begin
					pend_nxt = {16'h0, b[4:0]};
					left_nxt = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					pend_nxt = {17'h0, b[3:0]};
					left_nxt = 2'd2;
				end else begin
					pend_nxt = {18'h0, b[2:0]};
					left_nxt = 2'd3;
				end
				// A lead byte that ends the string gives its payload bits as a code point.
				if (in_item.in_last) begin
					push          = 1'b1;
					push_job.word = {{(DATA_W-CP_W){1'b0}}, pend_nxt};
					pend_nxt      = '0;
					left_nxt      = 2'd0;
				end
			end else begin
				push          = 1'b1;
				push_job.word = REPLACEMENT_CP;
			end
		end else begin
			pend_nxt = shifted;
			left_nxt = left_dec;
			if (left_dec == 2'd0 || in_item.in_last) begin
				push          = 1'b1;
				push_job.word = {{(DATA_W-CP_W){1'b0}}, shifted};
				pend_nxt      = '0;
				left_nxt      = 2'd0;
			end
		end
	end

	// Decode state; a direction write drops any partial character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			left_q <= 2'd0;
		end else if (cfg_clear) begin
			pend_q <= '0;
			left_q <= 2'd0;
		end else if (accept && dir == DIR_DECODE) begin
			pend_q <= pend_nxt;
			left_q <= left_nxt;
		end
	end

endmodule

// File: src/xcd_queue.sv
// Short job queue between the front and back ends of the transcoder.
// Depends on xcd_pkg for the job type.
module xcd_queue import xcd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == FULL_CNT);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Storage slots hold payload only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/xcd_back.sv
// Back end of the transcoder: splits the queue head job into result items,
// one per cycle unless stalled, via an output register. Depends on xcd_pkg.
module xcd_back import xcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      empty,
	output logic      pop,
	input  logic      out_stall,
	output logic      out_valid,
	output out_item_t out_item
);

	logic [1:0]  idx_q;
	logic        out_valid_q;
	out_item_t   out_item_q;
	logic        load;
	logic        elem_last;
	out_item_t   elem;

	assign load      = !out_valid_q || !out_stall;
	assign elem_last = (idx_q == head.cnt);
	assign pop       = load && !empty && elem_last;

	// Select the current element of the head job.
	always_comb begin
		elem          = '0;
		elem.out_last = elem_last;
		elem.out_end  = head.fin;
		if (head.cnt == 2'd0) begin
			elem.out_data = head.word;
		end else begin
			elem.out_data = {24'h0, head.word[{idx_q, 3'b000} +: 8]};
		end
	end

	// Element index within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (load && !empty) begin
			idx_q <= elem_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_item_q <= elem;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// File: src/xcd_checker.sv
// Port-level checks for the transcoder, attached to the top level by bind.
// Depends on xcd_pkg.
module xcd_checker import xcd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// No result ever exceeds 21 bits.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.out_data[31:21] == 11'h0)
		else $error("result above 21 bits");

	// Results that are not the last of their item are UTF-8 bytes.
	a_byte_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.out_last |-> out_item.out_data[31:8] == 24'h0)
		else $error("multi-result item gave a wide value");

	// The next byte of a character follows at once, as a continuation byte of the same item.
	a_cont_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.out_last |=>
		out_valid && out_item.out_data[7:6] == 2'b10 &&
		out_item.out_end == $past(out_item.out_end))
		else $error("continuation byte missing or malformed");

endmodule

bind utf8_utf32_transcoder_core xcd_checker u_xcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// File: verif/tb_utf8_utf32_transcoder_core.sv
// Self-checking testbench for utf8_utf32_transcoder_core: decode and encode item streams
// with random idling on both channels. Depends on xcd_pkg and the transcoder RTL.
module tb_utf8_utf32_transcoder_core;
	import xcd_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 9;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_MAX    = 10;
	localparam logic [ADDR_W-1:0] DIR_ADDR   = {REG_DIRECTION, 2'b00};
	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_item = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_item;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// Predictor state: mirrors the direction register and the partial character.
	logic        dir_mode = DIR_DECODE;
	logic [20:0] part_code = '0;
	logic [1:0]  cont_left = '0;

	in_item_t  text_items[$];
	out_item_t expected_units[$];
	int        queued = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        send_gap = 0;
	int        stall_left = 0;
	logic      idle_on = 1'b0;
	logic      in_taken = 1'b0;
	logic      moved;
	out_item_t want;

	utf8_utf32_transcoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
	endfunction

	task automatic push_unit(logic [31:0] data, logic last, logic fin);
		out_item_t u;
		u.out_data = data;
		u.out_last = last;
		u.out_end = fin;
		expected_units.push_back(u);
	endtask

	// Works out the output units that one accepted item causes.
	task automatic transcode_item(in_item_t it);
		logic [7:0]  b;
		logic [31:0] cp;
		logic        fin;
		b = it.in_data[7:0];
		cp = it.in_data;
		fin = it.in_last;
		if (dir_mode == DIR_ENCODE) begin
			if (cp < LIMIT_1B) begin
				push_unit(cp, 1'b1, fin);
			end else if (cp < LIMIT_2B) begin
				push_unit(32'hC0 | (cp >> 6), 1'b0, fin);
				push_unit(32'h80 | (cp & 32'h3F), 1'b1, fin);
			end else if (cp < LIMIT_3B) begin
				push_unit(32'hE0 | (cp >> 12), 1'b0, fin);
				push_unit(32'h80 | ((cp >> 6) & 32'h3F), 1'b0, fin);
				push_unit(32'h80 | (cp & 32'h3F), 1'b1, fin);
			end else begin
				// The lead byte keeps only its low eight bits for large words.
				push_unit((32'hF0 | (cp >> 18)) & 32'hFF, 1'b0, fin);
				push_unit(32'h80 | ((cp >> 12) & 32'h3F), 1'b0, fin);
				push_unit(32'h80 | ((cp >> 6) & 32'h3F), 1'b0, fin);
				push_unit(32'h80 | (cp & 32'h3F), 1'b1, fin);
			end
		end else if (cont_left == 2'd0 && b < 8'h80) begin
			push_unit({24'b0, b}, 1'b1, fin);
		end else begin
			if (cont_left == 2'd0) begin
				if (b[7:5] == 3'b110) begin
					part_code = {16'b0, b[4:0]};
					cont_left = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					part_code = {17'b0, b[3:0]};
					cont_left = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					part_code = {18'b0, b[2:0]};
					cont_left = 2'd3;
				end else begin
					push_unit(REPLACEMENT_CP, 1'b1, fin);
					return;
				end
			end else begin
				// Continuation bytes are taken unchecked, low six bits only.
				part_code = {part_code[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
			end
			// A character cut off by the end of the string is still given.
			if (cont_left == 2'd0 || fin) begin
				push_unit({11'b0, part_code}, 1'b1, fin);
				part_code = '0;
				cont_left = '0;
			end
		end
	endtask

	// Sender: presents queued items, holds each until accepted, idles in bursts.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			in_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 11);
				in_valid <= 1'b0;
			end else if (text_items.size() > 0) begin
				in_item <= text_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls the output channel in random bursts.
	always @(negedge clk) begin
		if (!arst_n || !idle_on) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: predicts on input handshakes, checks output items, guards against hangs.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				moved = 1'b1;
				transcode_item(in_item);
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_units.size() == 0) begin
					note_mismatch($sformatf("unexpected item data %h last %b end %b",
						out_item.out_data, out_item.out_last, out_item.out_end));
				end else begin
					want = expected_units.pop_front();
					if (out_item.out_data !== want.out_data ||
						out_item.out_last !== want.out_last ||
						out_item.out_end !== want.out_end) begin
						note_mismatch($sformatf(
							"data exp %h got %h, last exp %b got %b, end exp %b got %b",
							want.out_data, out_item.out_data, want.out_last,
							out_item.out_last, want.out_end, out_item.out_end));
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic queue_item(logic [31:0] data, logic last);
		in_item_t it;
		it.in_data = data;
		it.in_last = last;
		text_items.push_back(it);
		queued++;
	endtask

	// Waits until every item is sent and every expected result has come.
	task automatic settle();
		while (text_items.size() != 0 || in_valid || expected_units.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register transfer: a direction write updates the predictor, a read checks prdata.
	task automatic reg_access(logic wr, logic [ADDR_W-1:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata !== {31'b0, dir_mode}) begin
			note_mismatch($sformatf("direction readback exp %0d got %h", dir_mode, prdata));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr && addr == DIR_ADDR) begin
			dir_mode = value[0];
			part_code = '0;
			cont_left = '0;
		end
	endtask

	function automatic logic [31:0] with_junk(logic [7:0] b);
		logic [31:0] junk;
		junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'h0;
		return {junk[31:8], b};
	endfunction

	// Mostly well-formed UTF-8 characters, with noise bytes and cut-off sequences.
	task automatic queue_utf8_text(int count);
		int         stop;
		int         kind;
		int         len;
		int         cut;
		int         k;
		logic       fin;
		logic [7:0] lead;
		stop = queued + count;
		while (queued < stop) begin
			kind = $urandom_range(0, 99);
			len = (kind < 70) ? $urandom_range(1, 4) : $urandom_range(2, 4);
			case (len)
				1: lead = 8'($urandom_range(0, 8'h7F));
				2: lead = 8'hC0 | 8'($urandom_range(0, 8'h1F));
				3: lead = 8'hE0 | 8'($urandom_range(0, 8'h0F));
				default: lead = 8'hF0 | 8'($urandom_range(0, 8'h07));
			endcase
			fin = ($urandom_range(0, 11) == 0);
			if (kind < 70) begin
				queue_item(with_junk(lead), len == 1 && fin);
				for (k = 1; k < len; k++) begin
					queue_item(with_junk(8'h80 | 8'($urandom_range(0, 8'h3F))),
						k == len - 1 && fin);
				end
			end else if (kind < 85) begin
				queue_item(with_junk(8'($urandom_range(0, 255))), $urandom_range(0, 15) == 0);
			end else begin
				// Fewer continuation bytes than the lead asks for, any high bits.
				cut = $urandom_range(0, len - 2);
				fin = 1'($urandom_range(0, 1));
				queue_item(with_junk(lead), cut == 0 && fin);
				for (k = 1; k <= cut; k++) begin
					queue_item(with_junk(8'($urandom_range(0, 255))), k == cut && fin);
				end
			end
		end
	endtask

	// Code points spread over every encoded length, plus full 32-bit words.
	task automatic queue_code_points(int count);
		int          k;
		logic [31:0] cp;
		for (k = 0; k < count; k++) begin
			case ($urandom_range(0, 9))
				0, 1: cp = $urandom_range(0, 32'h7F);
				2, 3: cp = $urandom_range(32'h80, 32'h7FF);
				4, 5: cp = $urandom_range(32'h800, 32'hFFFF);
				6, 7: cp = $urandom_range(32'h10000, 32'h10FFFF);
				8: cp = $urandom_range(32'h110000, 32'h1FFFFF);
				default: cp = $urandom();
			endcase
			queue_item(cp, $urandom_range(0, 9) == 0);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		idle_on = 1'b1;

		// Directed decode: ASCII extremes, bad lead bytes, every sequence length.
		reg_access(1'b1, DIR_ADDR, 32'(DIR_DECODE));
		reg_access(1'b0, DIR_ADDR, 32'h0);
		queue_item(32'h00, 1'b0);
		queue_item(32'h7F, 1'b0);
		queue_item(32'h80, 1'b0);
		queue_item(32'hBF, 1'b0);
		queue_item(32'hF8, 1'b0);
		queue_item(32'hFF, 1'b1);
		queue_item(32'hC3, 1'b0);
		queue_item(32'hA9, 1'b0);
		queue_item(32'hE2, 1'b0);
		queue_item(32'h82, 1'b0);
		queue_item(32'hAC, 1'b0);
		queue_item(32'hF7, 1'b0);
		queue_item(32'hBF, 1'b0);
		queue_item(32'hBF, 1'b0);
		queue_item(32'hBF, 1'b0);
		// Truncated characters, a lead byte that ends the string, junk upper bits.
		queue_item(32'hE2, 1'b0);
		queue_item(32'h82, 1'b1);
		queue_item(32'hF0, 1'b1);
		queue_item(32'hFFFF_FF41, 1'b1);
		settle();

		// A direction write drops a character left part-way.
		queue_item(32'hE2, 1'b0);
		settle();
		reg_access(1'b1, DIR_ADDR, 32'(DIR_DECODE));
		queue_item(32'h41, 1'b0);
		// A write to an unmapped address keeps it; the continuation is not checked.
		queue_item(32'hC3, 1'b0);
		settle();
		reg_access(1'b1, SPARE_ADDR, 32'h1);
		queue_item(32'h29, 1'b1);
		settle();

		// Directed encode: range boundaries and words beyond 21 bits.
		reg_access(1'b1, DIR_ADDR, 32'(DIR_ENCODE));
		reg_access(1'b0, DIR_ADDR, 32'h0);
		queue_item(32'h0, 1'b0);
		queue_item(32'h7F, 1'b1);
		queue_item(32'h80, 1'b0);
		queue_item(32'h7FF, 1'b0);
		queue_item(32'h800, 1'b1);
		queue_item(32'hFFFF, 1'b0);
		queue_item(32'h10000, 1'b0);
		queue_item(32'h1FFFFF, 1'b1);
		queue_item(32'h200000, 1'b0);
		queue_item(32'hFFFF_FFFF, 1'b1);
		settle();

		// Random phases, alternating direction.
		reg_access(1'b1, DIR_ADDR, 32'(DIR_DECODE));
		queue_utf8_text(30);
		settle();
		reg_access(1'b1, DIR_ADDR, 32'(DIR_ENCODE));
		reg_access(1'b0, DIR_ADDR, 32'h0);
		queue_code_points(20);
		settle();
		idle_on = 1'b0;
		queue_code_points(15);
		settle();
		idle_on = 1'b1;
		reg_access(1'b1, DIR_ADDR, 32'(DIR_DECODE));
		reg_access(1'b0, DIR_ADDR, 32'h0);
		queue_utf8_text(30);
		settle();

		// Closing stretch at full rate on both sides.
		reg_access(1'b1, DIR_ADDR, 32'(DIR_ENCODE));
		idle_on = 1'b0;
		queue_code_points(20);
		settle();
		repeat (20) @(negedge clk);

		if (mismatches == 0 && expected_units.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
src/xcd_pkg.sv
src/xcd_front.sv
src/xcd_queue.sv
src/xcd_back.sv
src/utf8_utf32_transcoder_core.sv
src/xcd_checker.sv
verif/tb_utf8_utf32_transcoder_core.sv
